FILE: rtl/ordered_dither_shade_quantizer_macros.svh
// Assertion macros for the shade quantizer checker.
`ifndef ORDERED_DITHER_SHADE_QUANTIZER_MACROS_SVH
`define ORDERED_DITHER_SHADE_QUANTIZER_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define ODSQ_CHECK(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define ODSQ_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/odsq_pkg.sv
// Types, constants and lookup tables for the ordered-dither shade quantizer.
package odsq_pkg;

   localparam int PIX_W       = 8;
   localparam int POS_W       = 10;
   localparam int CFG_W       = 9;
   localparam int LEVEL_W     = 4;
   localparam int CHAR_W      = 7;
   localparam int FRAC_W      = 6;
   localparam int QUO_W       = 9;
   localparam int DITHER_W    = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int PIPE_DEPTH  = 5;
   localparam int STEPS_PER_STAGE = 3;

   typedef logic [PIX_W-1:0]       pixel_type;
   typedef logic [POS_W-1:0]       pos_type;
   typedef logic [CFG_W-1:0]       cfg_type;
   typedef logic [LEVEL_W-1:0]     level_type;
   typedef logic [CHAR_W-1:0]      char_type;
   typedef logic [FRAC_W-1:0]      thr_type;
   typedef logic [QUO_W-1:0]       quo_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type REG_BLACK_LEVEL = 2'd0;
   localparam csr_index_type REG_SHADE_RANGE = 2'd1;

   localparam cfg_type   BLACK_LEVEL_RESET = 9'd0;
   localparam cfg_type   SHADE_RANGE_RESET = 9'd256;
   localparam level_type BLANK_SHADE       = 4'd0;
   localparam level_type TOP_SHADE         = 4'd8;

   // 8x8 Bayer thresholds, indexed by {row[2:0], column[2:0]}
   localparam thr_type BAYER [64] = '{
      6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42,
      6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26,
      6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38,
      6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22,
      6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41,
      6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25,
      6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37,
      6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21
   };

   // ASCII ramp " .,:;!#$@"
   function automatic char_type ramp_char(input level_type lvl);
      char_type c;
      unique case (lvl)
         4'd0:    c = 7'd32;
         4'd1:    c = 7'd46;
         4'd2:    c = 7'd44;
         4'd3:    c = 7'd58;
         4'd4:    c = 7'd59;
         4'd5:    c = 7'd33;
         4'd6:    c = 7'd35;
         4'd7:    c = 7'd36;
         4'd8:    c = 7'd64;
         default: c = 7'd32;
      endcase
      return c;
   endfunction

endpackage

FILE: rtl/odsq_channels.sv
// Handshake channel interfaces: pixel request, shade response, register write.
interface odsq_req_if;
   import odsq_pkg::*;
   logic      valid;
   logic      ready;
   pixel_type pixel_value;
   pos_type   column;
   pos_type   row;
   modport source (output valid, pixel_value, column, row, input ready);
   modport sink   (input valid, pixel_value, column, row, output ready);
endinterface

interface odsq_rsp_if;
   import odsq_pkg::*;
   logic      valid;
   logic      ready;
   level_type shade_level;
   char_type  shade_char;
   modport source (output valid, shade_level, shade_char, input ready);
   modport sink   (input valid, shade_level, shade_char, output ready);
endinterface

interface odsq_csr_if;
   import odsq_pkg::*;
   logic          valid;
   logic          ready;
   csr_index_type index;
   cfg_type       write_data;
   modport source (output valid, index, write_data, input ready);
   modport sink   (input valid, index, write_data, output ready);
endinterface

FILE: rtl/ordered_dither_shade_quantizer.sv
// Ordered-dither shade quantizer: maps a pixel to a 9-level shade and its ramp character.
// Five-stage pipeline taking one item per clock while rsp_chan is not stalled; an accepted
// item passes through stages 1 to 5 in order before its result appears on rsp_chan.
// Stage 1 subtracts the black level and classifies the
// item as blank, full or in range; stages 2 to 4 form diff*512/shade_range with a restoring
// divider, three quotient bits per stage; stage 5 applies the 8x8 Bayer threshold and looks
// up the character, and is the output register. Each stage holds its item only while the
// one after it is full and stalled, so a stalled output still lets earlier empty stages
// fill. Registers are written through csr_chan (index 0 black_level, 1 shade_range; other
// indexes are ignored) and must only be changed while no item is in flight.
module ordered_dither_shade_quantizer (
   input logic         clock,
   input logic         reset,
   odsq_req_if.sink    req_chan,
   odsq_rsp_if.source  rsp_chan,
   odsq_csr_if.sink    csr_chan
);
   import odsq_pkg::*;

   // configuration registers
   cfg_type black_level_ff;
   cfg_type shade_range_ff;

   // per-stage state, stage 1 to PIPE_DEPTH
   logic    valid_ff [1:PIPE_DEPTH];
   logic    advance  [1:PIPE_DEPTH];
   logic    blank_ff [1:PIPE_DEPTH-1];
   logic    full_ff  [1:PIPE_DEPTH-1];
   thr_type thr_idx_ff [1:PIPE_DEPTH-1];
   cfg_type rem_ff   [1:PIPE_DEPTH-1];
   quo_type quo_ff   [1:PIPE_DEPTH-1];
   cfg_type rem_in   [2:PIPE_DEPTH-1];
   quo_type quo_in   [2:PIPE_DEPTH-1];

   level_type level_ff;
   char_type  char_ff;

   // stage 1 inputs
   logic    blank_in;
   logic    full_in;
   cfg_type diff_in;

   // stage 5 inputs
   logic      bump;
   level_type level_in;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         black_level_ff <= BLACK_LEVEL_RESET;
         shade_range_ff <= SHADE_RANGE_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_BLACK_LEVEL: black_level_ff <= csr_chan.write_data;
            REG_SHADE_RANGE: shade_range_ff <= csr_chan.write_data;
            default: ;
         endcase
      end
   end

   // a stage may load when empty or when its item moves on this cycle
   always_comb begin
      advance[PIPE_DEPTH] = !valid_ff[PIPE_DEPTH] || rsp_chan.ready;
      for (int k = PIPE_DEPTH - 1; k >= 1; k--) begin
         advance[k] = !valid_ff[k] || advance[k+1];
      end
   end

   assign req_chan.ready = advance[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= PIPE_DEPTH; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         if (advance[1]) begin
            valid_ff[1] <= req_chan.valid;
         end
         for (int k = 2; k <= PIPE_DEPTH; k++) begin
            if (advance[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   // stage 1: black level and range classification
   always_comb begin
      blank_in = {1'b0, req_chan.pixel_value} <= black_level_ff;
      diff_in  = {1'b0, req_chan.pixel_value} - black_level_ff;
      full_in  = diff_in >= shade_range_ff;
   end

   // one restoring step per quotient bit; for an in-range item the remainder stays below shade_range
   function automatic void div_steps(input cfg_type rem_i, input quo_type quo_i,
                                     input cfg_type divisor,
                                     output cfg_type rem_o, output quo_type quo_o);
      logic [CFG_W:0] twice;
      cfg_type        r;
      quo_type        q;
      r = rem_i;
      q = quo_i;
      for (int s = 0; s < STEPS_PER_STAGE; s++) begin
         twice = {r, 1'b0};
         if (twice >= {1'b0, divisor}) begin
            twice = twice - {1'b0, divisor};
            q     = {q[QUO_W-2:0], 1'b1};
         end else begin
            q     = {q[QUO_W-2:0], 1'b0};
         end
         r = twice[CFG_W-1:0];
      end
      rem_o = r;
      quo_o = q;
   endfunction

   always_comb begin
      for (int k = 2; k <= PIPE_DEPTH - 1; k++) begin
         div_steps(rem_ff[k-1], quo_ff[k-1], shade_range_ff, rem_in[k], quo_in[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance[1]) begin
         blank_ff[1]   <= blank_in;
         full_ff[1]    <= full_in;
         rem_ff[1]     <= diff_in;
         quo_ff[1]     <= '0;
         thr_idx_ff[1] <= {req_chan.row[DITHER_W-1:0], req_chan.column[DITHER_W-1:0]};
      end
      for (int k = 2; k <= PIPE_DEPTH - 1; k++) begin
         if (advance[k]) begin
            blank_ff[k]   <= blank_ff[k-1];
            full_ff[k]    <= full_ff[k-1];
            rem_ff[k]     <= rem_in[k];
            quo_ff[k]     <= quo_in[k];
            thr_idx_ff[k] <= thr_idx_ff[k-1];
         end
      end
   end

   // stage 5: dither against the Bayer threshold and pick the character
   always_comb begin
      bump = quo_ff[PIPE_DEPTH-1][FRAC_W-1:0] > BAYER[thr_idx_ff[PIPE_DEPTH-1]];
      priority if (blank_ff[PIPE_DEPTH-1]) begin
         level_in = BLANK_SHADE;
      end else if (full_ff[PIPE_DEPTH-1]) begin
         level_in = TOP_SHADE;
      end else begin
         level_in = {1'b0, quo_ff[PIPE_DEPTH-1][QUO_W-1:FRAC_W]} + {3'b000, bump};
      end
   end

   always_ff @(posedge clock) begin
      if (advance[PIPE_DEPTH]) begin
         level_ff <= level_in;
         char_ff  <= ramp_char(level_in);
      end
   end

   assign rsp_chan.valid       = valid_ff[PIPE_DEPTH];
   assign rsp_chan.shade_level = level_ff;
   assign rsp_chan.shade_char  = char_ff;

endmodule

FILE: rtl/odsq_checker.sv
// Port-level checker for the shade quantizer, bound to the top level.
`include "ordered_dither_shade_quantizer_macros.svh"

module odsq_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input odsq_pkg::level_type shade_level,
   input odsq_pkg::char_type  shade_char
);
   import odsq_pkg::*;

   // items accepted but not yet delivered
   logic [LEVEL_W-1:0] in_flight_ff;
   logic [LEVEL_W-1:0] in_flight_in;

   always_comb begin
      in_flight_in = in_flight_ff
                   + {{(LEVEL_W-1){1'b0}}, req_valid && req_ready}
                   - {{(LEVEL_W-1){1'b0}}, rsp_valid && rsp_ready};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_flight_ff <= '0;
      end else begin
         in_flight_ff <= in_flight_in;
      end
   end

   `ODSQ_CHECK_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(shade_level) && $stable(shade_char), "response changed while stalled")
   `ODSQ_CHECK(a_char_matches, !rsp_valid || (shade_level <= TOP_SHADE && shade_char == ramp_char(shade_level)), "shade level or character wrong")
   `ODSQ_CHECK(a_depth_bound, in_flight_ff <= LEVEL_W'(PIPE_DEPTH), "more items in flight than stages")
   `ODSQ_CHECK(a_no_phantom, !rsp_valid || in_flight_ff != '0, "response without an accepted item")

endmodule

bind ordered_dither_shade_quantizer odsq_checker u_odsq_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .shade_level (rsp_chan.shade_level),
   .shade_char  (rsp_chan.shade_char)
);

FILE: bench/tb_ordered_dither_shade_quantizer.sv
`timescale 1ns / 1ps
// Self-checking bench for the shade quantizer: corner pixels and settings, then random pixels.
module tb_ordered_dither_shade_quantizer;
   import odsq_pkg::*;

   localparam int CLOCK_PERIOD     = 8;
   localparam int RESET_CYCLES     = 9;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int RANDOM_PHASES    = 12;
   localparam int PHASE_ITEMS      = 120;
   localparam csr_index_type REG_SPARE = 2'd3;   // not decoded, writes must be ignored

   // " .,:;!#$@"
   localparam char_type SHADE_GLYPH [9] = '{
      7'd32, 7'd46, 7'd44, 7'd58, 7'd59, 7'd33, 7'd35, 7'd36, 7'd64
   };

   typedef struct packed {
      pixel_type pix;
      pos_type   col;
      pos_type   row;
   } pixel_item_type;

   typedef struct packed {
      level_type level;
      char_type  glyph;
   } shade_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   odsq_req_if req_chan ();
   odsq_rsp_if rsp_chan ();
   odsq_csr_if csr_chan ();

   ordered_dither_shade_quantizer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   pixel_item_type pixel_pending [$];
   shade_type      shade_expected [$];

   cfg_type     black_cfg       = BLACK_LEVEL_RESET;
   cfg_type     span_cfg        = SHADE_RANGE_RESET;
   int unsigned sender_idle_pct = 0;
   int unsigned rsp_stall_pct   = 0;
   logic        sender_paused   = 1'b0;
   logic        long_hold_req   = 1'b0;
   int unsigned hold_left       = 0;
   int unsigned mismatches      = 0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic shade_type predict_shade(pixel_item_type it, cfg_type black,
                                               cfg_type span);
      int unsigned diff;
      int unsigned scaled;
      level_type   lvl;
      thr_type     thr;
      if (it.pix <= black) begin
         lvl = BLANK_SHADE;
      end else begin
         diff = it.pix - black;
         if (diff >= span) begin
            lvl = TOP_SHADE;   // also covers a zero range, no divide
         end else begin
            scaled = diff * 512 / span;
            thr    = BAYER[{it.row[2:0], it.col[2:0]}];
            lvl    = level_type'(scaled >> 6);
            if ((scaled % 64) > thr)
               lvl = lvl + 1'b1;
            if (lvl > TOP_SHADE)
               lvl = TOP_SHADE;
         end
      end
      return '{level: lvl, glyph: SHADE_GLYPH[lvl]};
   endfunction

   // Mostly pixels inside the stretched span, the rest anywhere
   function automatic pixel_item_type random_pixel(cfg_type black, cfg_type span);
      pixel_item_type it;
      int lo;
      int hi;
      it.col = pos_type'($urandom_range(1023));
      it.row = pos_type'($urandom_range(1023));
      lo = black + 1;
      hi = black + span;
      if (hi > 255)
         hi = 255;
      if ($urandom_range(9) < 7 && lo <= hi)
         it.pix = pixel_type'($urandom_range(hi, lo));
      else
         it.pix = pixel_type'($urandom_range(255));
      return it;
   endfunction

   function automatic void queue_pixel(pixel_type p, pos_type c, pos_type r);
      pixel_pending.push_back('{pix: p, col: c, row: r});
   endfunction

   // Pixel driver: predicts on acceptance, then offers the next item or idles
   always @(posedge clock) begin : pixel_driver
      pixel_item_type next_item;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            shade_expected.push_back(predict_shade('{pix: req_chan.pixel_value,
                                                     col: req_chan.column,
                                                     row: req_chan.row},
                                                   black_cfg, span_cfg));
         if (!req_chan.valid || req_chan.ready) begin
            if (pixel_pending.size() != 0 && !sender_paused &&
                $urandom_range(99) >= sender_idle_pct) begin
               next_item = pixel_pending.pop_front();
               req_chan.valid       <= 1'b1;
               req_chan.pixel_value <= next_item.pix;
               req_chan.column      <= next_item.col;
               req_chan.row         <= next_item.row;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Shade monitor
   always @(posedge clock) begin : shade_monitor
      shade_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (shade_expected.size() == 0) begin
               $display("%0t: unexpected item: expected none, got level %0d char %0d",
                        $time, rsp_chan.shade_level, rsp_chan.shade_char);
               mismatches++;
            end else begin
               want = shade_expected.pop_front();
               if (rsp_chan.shade_level !== want.level) begin
                  $display("%0t: shade_level mismatch: expected %0d, got %0d",
                           $time, want.level, rsp_chan.shade_level);
                  mismatches++;
               end
               if (rsp_chan.shade_char !== want.glyph) begin
                  $display("%0t: shade_char mismatch: expected %0d, got %0d",
                           $time, want.glyph, rsp_chan.shade_char);
                  mismatches++;
               end
            end
         end
         rsp_chan.ready <= (hold_left == 0) && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Long receiver hold-off, counted here
   always @(posedge clock) begin
      if (reset)
         hold_left <= 0;
      else if (long_hold_req)
         hold_left <= LONG_HOLD_CYCLES;
      else if (hold_left != 0)
         hold_left <= hold_left - 1;
   end

   task automatic set_idle(int unsigned sender, int unsigned receiver);
      sender_idle_pct <= sender;
      rsp_stall_pct   <= receiver;
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pixel_pending.size() != 0 || req_chan.valid || shade_expected.size() != 0);
   endtask

   // Back-to-back register writes, valid held high across them
   task automatic program_regs(cfg_type black, cfg_type span, bit poke_spare);
      csr_chan.valid      <= 1'b1;
      csr_chan.index      <= REG_BLACK_LEVEL;
      csr_chan.write_data <= black;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.index      <= REG_SHADE_RANGE;
      csr_chan.write_data <= span;
      do @(posedge clock); while (!csr_chan.ready);
      if (poke_spare) begin
         csr_chan.index      <= REG_SPARE;
         csr_chan.write_data <= cfg_type'($urandom);
         do @(posedge clock); while (!csr_chan.ready);
      end
      csr_chan.valid <= 1'b0;
      black_cfg      <= black;
      span_cfg       <= span;
   endtask

   initial begin : run_timeout
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : stimulus
      int unsigned phase;
      cfg_type     black;
      cfg_type     span;
      req_chan.valid       = 1'b0;
      req_chan.pixel_value = '0;
      req_chan.column      = '0;
      req_chan.row         = '0;
      rsp_chan.ready       = 1'b0;
      csr_chan.valid       = 1'b0;
      csr_chan.index       = REG_BLACK_LEVEL;
      csr_chan.write_data  = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset settings: blank, top, first dither step, field extremes
      queue_pixel(8'd0,   10'd0,     10'd0);
      queue_pixel(8'd255, 10'd1023,  10'd1023);
      queue_pixel(8'd1,   10'd0,     10'd0);
      queue_pixel(8'd128, 10'd7,     10'd7);
      queue_pixel(8'd255, 10'd0,     10'd0);
      queue_pixel(8'd160, 10'h2aa,   10'h155);
      queue_pixel(8'd100, 10'd3,     10'd4);
      wait_drained();
      // black level above, equal to and just below the pixel
      program_regs(9'd200, 9'd100, 1'b0);
      queue_pixel(8'd100, 10'd0, 10'd0);
      queue_pixel(8'd200, 10'd5, 10'd5);
      queue_pixel(8'd201, 10'd0, 10'd0);
      queue_pixel(8'd255, 10'd7, 10'd0);
      wait_drained();
      // zero range: any positive difference is full
      program_regs(9'd0, 9'd0, 1'b1);
      queue_pixel(8'd0,   10'd1, 10'd2);
      queue_pixel(8'd1,   10'd3, 10'd4);
      queue_pixel(8'd255, 10'd5, 10'd6);
      wait_drained();
      program_regs(9'd256, 9'd256, 1'b0);
      queue_pixel(8'd255, 10'd0, 10'd0);
      wait_drained();
      program_regs(9'd511, 9'd511, 1'b0);
      queue_pixel(8'd255, 10'd1023, 10'd0);
      wait_drained();
      // range above the usual maximum
      program_regs(9'd0, 9'd511, 1'b0);
      queue_pixel(8'd255, 10'd0, 10'd7);
      queue_pixel(8'd128, 10'd6, 10'd2);
      wait_drained();
      program_regs(9'd0, 9'd1, 1'b0);
      queue_pixel(8'd1, 10'd0, 10'd0);
      queue_pixel(8'd0, 10'd0, 10'd0);
      wait_drained();
      program_regs(9'd0, 9'd257, 1'b0);
      queue_pixel(8'd255, 10'd0, 10'd0);
      queue_pixel(8'd1,   10'd0, 10'd0);
      wait_drained();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       begin black = BLACK_LEVEL_RESET; span = SHADE_RANGE_RESET; end
            1:       begin black = 9'd0;   span = 9'd1;   end
            2:       begin black = 9'd0;   span = 9'd257; end
            3:       begin black = 9'd128; span = 9'd1;   end
            4:       begin black = 9'd0;   span = 9'd511; end
            5:       begin black = 9'd256; span = 9'd257; end
            6:       begin black = cfg_type'($urandom_range(200)); span = 9'd0; end
            default: begin
               black = cfg_type'($urandom_range(200));
               span  = cfg_type'($urandom_range(257, 1));
            end
         endcase
         program_regs(black, span, phase[0]);
         case (phase % 4)
            0: set_idle(0, 0);
            1: set_idle(65, 0);
            2: set_idle(0, 65);
            default: set_idle(38, 38);
         endcase
         repeat (PHASE_ITEMS) pixel_pending.push_back(random_pixel(black, span));
         wait_drained();
      end

      // receiver holds off while the sender keeps offering, so the pipe backs up
      black = cfg_type'($urandom_range(100));
      span  = cfg_type'($urandom_range(257, 1));
      program_regs(black, span, 1'b0);
      set_idle(0, 0);
      long_hold_req <= 1'b1;
      repeat (60) pixel_pending.push_back(random_pixel(black, span));
      do @(posedge clock); while (hold_left == 0);
      long_hold_req <= 1'b0;
      wait_drained();

      // sender stops halfway until every outstanding shade is back
      set_idle(0, 65);
      repeat (100) pixel_pending.push_back(random_pixel(black, span));
      do @(posedge clock); while (pixel_pending.size() > 50);
      sender_paused <= 1'b1;
      do @(posedge clock); while (req_chan.valid || shade_expected.size() != 0);
      sender_paused <= 1'b0;
      wait_drained();

      set_idle(0, 0);
      repeat (PIPE_DEPTH * 4) @(posedge clock);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
